@@ rtl/core/tsq_pkg.sv @@
package tsq_pkg;

    localparam int ROWS         = 7;
    localparam int COLS         = 5;
    localparam int CELLS        = ROWS * COLS;
    localparam int SYMBOL_WIDTH = 16;
    localparam int INDEX_WIDTH  = 6;
    localparam int ROW_W        = $clog2(ROWS);
    localparam int COL_W        = $clog2(COLS);
    localparam int CELL_W       = $clog2(CELLS);

    typedef enum logic [1:0] {
        CMD_LOAD_LEFT  = 2'd0,
        CMD_LOAD_RIGHT = 2'd1,
        CMD_ENCODE     = 2'd2,
        CMD_DECODE     = 2'd3
    } cmd_t;

    typedef logic [SYMBOL_WIDTH-1:0] symbol_t;

    typedef logic [CELLS-1:0][SYMBOL_WIDTH-1:0] square_t;

    typedef struct packed {
        cmd_t                   command;
        logic [INDEX_WIDTH-1:0] entry_index;
        symbol_t                symbol_a;
        symbol_t                symbol_b;
    } req_t;

    typedef struct packed {
        symbol_t out_a;
        symbol_t out_b;
        logic    not_found;
    } rsp_t;

    typedef struct packed {
        logic             found;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } locate_t;

endpackage

@@ rtl/core/tsq_if.sv @@
interface tsq_req_if;
    logic            valid;
    logic            ready;
    tsq_pkg::req_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tsq_rsp_if;
    logic            valid;
    logic            ready;
    tsq_pkg::rsp_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/two_square_bigram_cipher.sv @@
// A request passes through the input stage register, then its result is held in the output register.
// Throughput: one request per cycle unless a held result stalls the output; a load takes its slot but makes no result.
// The rate is set by the single pass of parallel square search and crossed read.
// Reset clears the pipeline valid flags only; square entries are undefined
// until loaded, and no cipher request may be sent before both squares are full.
module two_square_bigram_cipher (
    input  logic          clk,
    input  logic          rst_n,
    tsq_req_if.sink       req,
    tsq_rsp_if.source     rsp
);

    logic              stage_valid_reg;
    logic              stage_valid_next;
    tsq_pkg::req_t     stage_item_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    tsq_pkg::rsp_t     out_item_reg;
    tsq_pkg::rsp_t     out_item_next;
    tsq_pkg::square_t  left_square_reg;
    tsq_pkg::square_t  right_square_reg;

    logic              stage_is_load;
    logic              out_free;
    logic              stage_advance;
    logic              emit;
    logic              load_write;
    tsq_pkg::symbol_t  left_key;
    tsq_pkg::symbol_t  right_key;
    tsq_pkg::locate_t  left_loc;
    tsq_pkg::locate_t  right_loc;
    logic [tsq_pkg::CELL_W-1:0] left_read_idx;
    logic [tsq_pkg::CELL_W-1:0] right_read_idx;
    tsq_pkg::symbol_t  left_read;
    tsq_pkg::symbol_t  right_read;

    assign stage_is_load = (stage_item_reg.command == tsq_pkg::CMD_LOAD_LEFT)
                        || (stage_item_reg.command == tsq_pkg::CMD_LOAD_RIGHT);
    assign out_free      = !out_valid_reg || rsp.ready;
    assign stage_advance = stage_valid_reg && (stage_is_load || out_free);
    assign emit          = stage_valid_reg && !stage_is_load && out_free;
    assign req.ready     = !stage_valid_reg || stage_advance;
    assign load_write    = stage_valid_reg && stage_is_load
                        && (stage_item_reg.entry_index < tsq_pkg::INDEX_WIDTH'(tsq_pkg::CELLS));

    always_comb
    begin
        if (req.valid && req.ready)
        begin
            stage_valid_next = 1'b1;
        end
        else if (stage_advance)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            stage_item_reg <= req.payload;
        end
    end

    // Key squares: loads with an index below CELLS are written as they leave the input stage,
    // so every later cipher request sees them.
    always_ff @(posedge clk)
    begin
        if (load_write)
        begin
            if (stage_item_reg.command == tsq_pkg::CMD_LOAD_LEFT)
            begin
                left_square_reg[stage_item_reg.entry_index[tsq_pkg::CELL_W-1:0]]
                    <= stage_item_reg.symbol_a;
            end
            else
            begin
                right_square_reg[stage_item_reg.entry_index[tsq_pkg::CELL_W-1:0]]
                    <= stage_item_reg.symbol_a;
            end
        end
    end

    // Encode searches the first symbol on the left; decode searches the second.
    assign left_key  = (stage_item_reg.command == tsq_pkg::CMD_ENCODE)
                     ? stage_item_reg.symbol_a : stage_item_reg.symbol_b;
    assign right_key = (stage_item_reg.command == tsq_pkg::CMD_ENCODE)
                     ? stage_item_reg.symbol_b : stage_item_reg.symbol_a;

    tsq_locate u_locate_left (
        .square (left_square_reg),
        .symbol (left_key),
        .result (left_loc)
    );

    tsq_locate u_locate_right (
        .square (right_square_reg),
        .symbol (right_key),
        .result (right_loc)
    );

    // The crossed positions are the same for both directions; only the order
    // of the two answers differs.
    always_comb
    begin
        if (left_loc.row == right_loc.row)
        begin
            left_read_idx  = tsq_pkg::CELL_W'(left_loc.row)
                           * tsq_pkg::CELL_W'(tsq_pkg::COLS)
                           + tsq_pkg::CELL_W'(right_loc.col);
            right_read_idx = tsq_pkg::CELL_W'(right_loc.row)
                           * tsq_pkg::CELL_W'(tsq_pkg::COLS)
                           + tsq_pkg::CELL_W'(left_loc.col);
        end
        else
        begin
            left_read_idx  = tsq_pkg::CELL_W'(right_loc.row)
                           * tsq_pkg::CELL_W'(tsq_pkg::COLS)
                           + tsq_pkg::CELL_W'(left_loc.col);
            right_read_idx = tsq_pkg::CELL_W'(left_loc.row)
                           * tsq_pkg::CELL_W'(tsq_pkg::COLS)
                           + tsq_pkg::CELL_W'(right_loc.col);
        end
    end

    assign left_read  = left_square_reg[left_read_idx];
    assign right_read = right_square_reg[right_read_idx];

    always_comb
    begin
        if (!left_loc.found || !right_loc.found)
        begin
            out_item_next.out_a     = '0;
            out_item_next.out_b     = '0;
            out_item_next.not_found = 1'b1;
        end
        else if (stage_item_reg.command == tsq_pkg::CMD_ENCODE)
        begin
            out_item_next.out_a     = right_read;
            out_item_next.out_b     = left_read;
            out_item_next.not_found = 1'b0;
        end
        else
        begin
            out_item_next.out_a     = left_read;
            out_item_next.out_b     = right_read;
            out_item_next.not_found = 1'b0;
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_item_reg;

    // A load leaves the output side exactly as a plain idle cycle would.
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && stage_is_load)
        |=> (out_valid_reg == $past(out_valid_reg && !rsp.ready)))
        else $error("load request produced a result");

    // A cipher request that leaves the input stage always shows up as a result.
    a_cipher_emits: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("cipher request lost between stages");

    // A request held in the input stage is neither dropped nor overwritten.
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !stage_advance)
        |=> (stage_valid_reg && $stable(stage_item_reg)))
        else $error("stalled request overwritten");

    // A missing symbol always yields zero symbols.
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.not_found)
        |-> (out_item_reg.out_a == '0 && out_item_reg.out_b == '0))
        else $error("not_found result carries symbols");

endmodule

@@ rtl/core/tsq_locate.sv @@
module tsq_locate (
    input  tsq_pkg::square_t  square,
    input  tsq_pkg::symbol_t  symbol,
    output tsq_pkg::locate_t  result
);

    logic [tsq_pkg::CELLS-1:0] match;
    logic [tsq_pkg::CELLS-1:0] first;

    always_comb
    begin
        for (int k = 0; k < tsq_pkg::CELLS; k++)
        begin
            match[k] = (square[k] == symbol);
        end
    end

    // Isolate the lowest set bit, which is the first match in row-major order.
    assign first = match & (~match + {{(tsq_pkg::CELLS-1){1'b0}}, 1'b1});

    always_comb
    begin
        result.found = |match;
        result.row   = '0;
        result.col   = '0;
        for (int r = 0; r < tsq_pkg::ROWS; r++)
        begin
            for (int c = 0; c < tsq_pkg::COLS; c++)
            begin
                if (first[r * tsq_pkg::COLS + c])
                begin
                    result.row = result.row | tsq_pkg::ROW_W'(r);
                    result.col = result.col | tsq_pkg::COL_W'(c);
                end
            end
        end
    end

endmodule
